// ----- rtl/pvf_pkg.sv -----
`timescale 1ns / 1ps

package pvf_pkg;

  // Frame store geometry
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int COLCNT_W   = $clog2(MAX_WIDTH + 1);
  localparam int ROWCNT_W   = $clog2(MAX_HEIGHT + 1);
  localparam int ADDR_W     = ROW_W + COL_W;
  localparam int PIX_W      = 24;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int CHAN_W     = 3;
  localparam int DIM_W      = 11;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd2;

  localparam logic [CHAN_W-1:0] CHAN_RESET = 3'd3;
  localparam logic [DIM_W-1:0]  WIDTH_RESET  = DIM_W'(1024);
  localparam logic [DIM_W-1:0]  HEIGHT_RESET = DIM_W'(1024);

  // Request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // Pixel fill for unsupported channel counts
  localparam logic [PIX_W-1:0] PIX_ONES = 24'h010101;

  typedef enum logic {
    S_EMPTY,
    S_FULL
  } pvf_state_t;

  typedef struct packed {
    logic mem_wr;
    logic mem_rd;
  } pvf_cmd_t;

  // Saturate a configured width to 1..MAX_WIDTH
  function automatic logic [COLCNT_W-1:0] clamp_width(input logic [DIM_W-1:0] v);
    logic [COLCNT_W-1:0] r;
    if (v == '0) begin
      r = COLCNT_W'(1);
    end else if (32'(v) > 32'(MAX_WIDTH)) begin
      r = COLCNT_W'(MAX_WIDTH);
    end else begin
      r = COLCNT_W'(v);
    end
    return r;
  endfunction

  // Saturate a configured height to 1..MAX_HEIGHT
  function automatic logic [ROWCNT_W-1:0] clamp_height(input logic [DIM_W-1:0] v);
    logic [ROWCNT_W-1:0] r;
    if (v == '0) begin
      r = ROWCNT_W'(1);
    end else if (32'(v) > 32'(MAX_HEIGHT)) begin
      r = ROWCNT_W'(MAX_HEIGHT);
    end else begin
      r = ROWCNT_W'(v);
    end
    return r;
  endfunction

endpackage

// ----- rtl/pvf_ctrl.sv -----
`timescale 1ns / 1ps

module pvf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              req_type,
  output logic              out_valid,
  input  logic              out_ready,
  output pvf_pkg::pvf_cmd_t cmd
);
  import pvf_pkg::*;

  pvf_state_t state;
  pvf_state_t state_next;
  logic       accept;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_EMPTY;
    end else begin
      state <= state_next;
    end
  end

  // Take writes always; take a read when the output slot is free or draining
  always_comb begin
    in_ready   = (state == S_EMPTY) || (req_type == REQ_WRITE) || out_ready;
    accept     = in_valid && in_ready;
    cmd.mem_wr = accept && (req_type == REQ_WRITE);
    cmd.mem_rd = accept && (req_type == REQ_READ);
    out_valid  = (state == S_FULL);
    state_next = state;
    case (state)
      S_EMPTY: begin
        if (cmd.mem_rd) state_next = S_FULL;
      end
      S_FULL: begin
        if (!cmd.mem_rd && out_ready) state_next = S_EMPTY;
      end
      default: state_next = S_EMPTY;
    endcase
  end

endmodule

// ----- rtl/pvf_datapath.sv -----
`timescale 1ns / 1ps

module pvf_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  pvf_pkg::pvf_cmd_t               cmd,
  input  logic                            cfg_we,
  input  logic [pvf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pvf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [7:0]                      src_byte0,
  input  logic [7:0]                      src_byte1,
  input  logic [7:0]                      src_byte2,
  output logic [7:0]                      out_byte0,
  output logic [7:0]                      out_byte1,
  output logic [7:0]                      out_byte2,
  output logic                            frame_end
);
  import pvf_pkg::*;

  logic [CHAN_W-1:0]   channel_count;
  logic [DIM_W-1:0]    frame_width;
  logic [DIM_W-1:0]    frame_height;

  logic [COL_W-1:0]    write_col, write_col_next;
  logic [ROW_W-1:0]    write_row, write_row_next;
  logic [COL_W-1:0]    read_col, read_col_next;
  logic [ROW_W-1:0]    read_row, read_row_next;

  logic [COLCNT_W-1:0] w_eff;
  logic [ROWCNT_W-1:0] h_eff;
  logic                wcol_wrap, wrow_wrap, rcol_wrap, rrow_wrap;
  logic [ROW_W-1:0]    mirror_row;
  logic [ADDR_W-1:0]   wr_addr, rd_addr;
  logic [PIX_W-1:0]    wr_pix;
  logic [PIX_W-1:0]    rd_pix;

  logic [PIX_W-1:0]    mem [2**ADDR_W];

  // Update configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= CHAN_RESET;
      frame_width   <= WIDTH_RESET;
      frame_height  <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHANNEL_COUNT: channel_count <= cfg_data[CHAN_W-1:0];
        REG_FRAME_WIDTH:   frame_width   <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT:  frame_height  <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Convert the source pixel to three bytes
  always_comb begin
    case (channel_count)
      3'd3, 3'd4: wr_pix = {src_byte2, src_byte1, src_byte0};
      3'd1:       wr_pix = {src_byte0, src_byte0, src_byte0};
      default:    wr_pix = PIX_ONES;
    endcase
  end

  // Advance the pointers with wrap at the frame edge
  always_comb begin
    w_eff     = clamp_width(frame_width);
    h_eff     = clamp_height(frame_height);
    wcol_wrap = (COLCNT_W'(write_col) + COLCNT_W'(1)) >= w_eff;
    wrow_wrap = (ROWCNT_W'(write_row) + ROWCNT_W'(1)) >= h_eff;
    rcol_wrap = (COLCNT_W'(read_col) + COLCNT_W'(1)) >= w_eff;
    rrow_wrap = (ROWCNT_W'(read_row) + ROWCNT_W'(1)) >= h_eff;

    write_col_next = wcol_wrap ? '0 : write_col + COL_W'(1);
    write_row_next = write_row;
    if (wcol_wrap) write_row_next = wrow_wrap ? '0 : write_row + ROW_W'(1);

    read_col_next = rcol_wrap ? '0 : read_col + COL_W'(1);
    read_row_next = read_row;
    if (rcol_wrap) read_row_next = rrow_wrap ? '0 : read_row + ROW_W'(1);

    // Mirror the read row; a row beyond a shrunk frame maps to row zero
    if (ROWCNT_W'(read_row) < h_eff) begin
      mirror_row = ROW_W'(h_eff - ROWCNT_W'(1) - ROWCNT_W'(read_row));
    end else begin
      mirror_row = '0;
    end

    wr_addr = {write_row, write_col};
    rd_addr = {mirror_row, read_col};
  end

  // Move the pointers on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      write_col <= '0;
      write_row <= '0;
      read_col  <= '0;
      read_row  <= '0;
    end else begin
      if (cmd.mem_wr) begin
        write_col <= write_col_next;
        write_row <= write_row_next;
      end
      if (cmd.mem_rd) begin
        read_col <= read_col_next;
        read_row <= read_row_next;
      end
    end
  end

  // Frame store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) mem[wr_addr] <= wr_pix;
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      rd_pix    <= mem[rd_addr];
      frame_end <= rcol_wrap && rrow_wrap;
    end
  end

  assign out_byte0 = rd_pix[7:0];
  assign out_byte1 = rd_pix[15:8];
  assign out_byte2 = rd_pix[23:16];

endmodule

// ----- rtl/pixel_to_rgb3_vertical_flip.sv -----
`timescale 1ns / 1ps

// Channel conversion with vertical flip. A write word (req_type 0) converts one source
// pixel to three bytes by channel_count (4 drops the alpha byte, 3 copies, 1 replicates
// the gray byte, any other count gives bytes of value 1) and stores it at the next
// raster position of a 1024x1024x24-bit frame store; it gives no output word. A read
// word (req_type 1) returns the next pixel in raster order with the rows reversed, and
// frame_end marks the last pixel of the mirrored frame. Both pointers wrap at the end
// of the frame set by frame_width and frame_height (saturated to 1..1024). One input
// word is taken per clock; a read result appears the cycle after acceptance, out of the
// registered read port of the store, and a further read is taken only while that result
// is free or is being taken in the same cycle. The store is not cleared after reset: a
// pixel must be written before it is read. Change configuration only while idle.
module pixel_to_rgb3_vertical_flip (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pvf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pvf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            req_type,
  input  logic [7:0]                      src_byte0,
  input  logic [7:0]                      src_byte1,
  input  logic [7:0]                      src_byte2,
  input  logic [7:0]                      src_byte3,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_byte0,
  output logic [7:0]                      out_byte1,
  output logic [7:0]                      out_byte2,
  output logic                            frame_end
);
  import pvf_pkg::*;

  pvf_cmd_t cmd;
  logic     alpha_unused;

  // Alpha byte is always discarded
  assign alpha_unused = ^src_byte3;

  pvf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  pvf_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .src_byte0 (src_byte0),
    .src_byte1 (src_byte1),
    .src_byte2 (src_byte2),
    .out_byte0 (out_byte0),
    .out_byte1 (out_byte1),
    .out_byte2 (out_byte2),
    .frame_end (frame_end)
  );

endmodule
